FILE: design/assert_macros.svh
// Assertion helpers for the design files; the integrator unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cvi_pkg.sv
package cvi_pkg;

  localparam int unsigned MassCountDefault = 1024;
  localparam int unsigned IndexWidth = 10;
  localparam int unsigned DtWidth = 24;
  localparam int unsigned CapWidth = 31;
  localparam int unsigned CfgWidth = 31;
  localparam logic [23:0] DtReset = 24'd1093;
  localparam logic [30:0] CapReset = 31'd65536;
  localparam logic CfgIdxDt = 1'b0;
  localparam logic CfgIdxCap = 1'b1;
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqForce = 1'b1;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

FILE: design/cvi_ram.sv
// Single-port RAM with registered read data.
module cvi_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

FILE: design/cvi_div.sv
// Bit-serial restoring divider; one quotient bit per cycle.
module cvi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [33:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q, quo_d;
  logic [34:0] rem_q, rem_d;
  logic [33:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [34:0] shifted;

  // Shift in the next dividend bit and trial-subtract.
  always_comb begin
    shifted = {rem_q[33:0], quo_q[63]};
    quo_d   = {quo_q[62:0], 1'b0};
    rem_d   = shifted;
    if (shifted >= {1'b0, den_q}) begin
      rem_d    = shifted - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o = quo_q;
endmodule

FILE: design/capped_velocity_integrator_unit.sv
// Integrates one point mass per force word marked last: v += F*dt, clamp |v| to
// cap*dt, pos += v*dt. A load word writes the position and zeroes the velocity and
// force sum; a plain force word adds into the stored force sum. A clamped last
// force word also runs a bit-serial square root and two divisions. A result is held
// while out_stall_i is high. All products run through one shared 33x34 multiplier
// under a small sequencer, and the block takes no new word until the current one
// is done. After reset a clearing pass zeroes the force sum of every mass; no word
// is taken meanwhile.
module capped_velocity_integrator_unit #(
  parameter int unsigned MassCount = cvi_pkg::MassCountDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [cvi_pkg::IndexWidth-1:0]  mass_index_i,
  input  logic signed [31:0]              value_x_i,
  input  logic signed [31:0]              value_y_i,
  input  logic                            last_force_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cvi_pkg::IndexWidth-1:0]  out_index_o,
  output logic signed [31:0]              new_pos_x_o,
  output logic signed [31:0]              new_pos_y_o,
  output logic signed [31:0]              new_vel_x_o,
  output logic signed [31:0]              new_vel_y_o,
  output logic                            was_capped_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [cvi_pkg::CfgWidth-1:0]    cfg_data_i
);
  import cvi_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW = (MassCount > 1) ? $clog2(MassCount) : 1;

  localparam logic [4:0] S_CLR  = 5'd0,  S_IDLE = 5'd1,  S_RD   = 5'd2,  S_ACC  = 5'd3,
                         S_FX   = 5'd4,  S_FY   = 5'd5,  S_CAP  = 5'd6,  S_SQX  = 5'd7,
                         S_SQY  = 5'd8,  S_CMP  = 5'd9,  S_SQRT = 5'd10, S_DVX  = 5'd11,
                         S_WDX  = 5'd12, S_DVY  = 5'd13, S_WDY  = 5'd14, S_PX   = 5'd15,
                         S_PY   = 5'd16, S_WR   = 5'd17, S_OUT  = 5'd18, S_LOAD = 5'd19,
                         S_MVX  = 5'd20, S_MVY  = 5'd21;

  logic [4:0]  state_q, state_d;
  logic [23:0] dt_q;
  logic [30:0] cap_cfg_q;
  logic [AW-1:0] clr_q;

  // Held request.
  logic          typ_q, last_q;
  logic [IndexWidth-1:0] idx_q;
  logic signed [31:0] ix_q, iy_q;

  // Working values.
  logic signed [31:0] fx_q, fy_q, vx_q, vy_q, px_q, py_q;
  logic [33:0] capv_q;
  logic        capbig_q, capped_q;
  logic [63:0] sq_q, vprod_q;
  logic [63:0] rt_s_q, rt_res_q, rt_bit_q;
  logic [5:0]  rt_cnt_q;

  // Shared multiplier: signed 33 x unsigned 33, registered result.
  logic signed [32:0] ma;
  logic [32:0]        mb;
  logic signed [66:0] mprod;
  logic signed [66:0] mp_q;
  assign mprod = ma * $signed({1'b0, mb});

  // Rounded Q16 product magnitude with the sign restored.
  function automatic logic signed [50:0] rnd16(input logic signed [66:0] p);
    logic [66:0] m;
    logic [66:0] r;
    m = p[66] ? 67'(-p) : 67'(p);
    r = (m + 67'h8000) >> 16;
    return p[66] ? -$signed(51'(r)) : $signed(51'(r));
  endfunction

  logic signed [50:0] mr;
  assign mr = rnd16(mp_q);

  function automatic logic signed [31:0] sat51(input logic signed [50:0] v);
    if (v > 51'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -51'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Memories: position, velocity, force sum.
  logic [AW-1:0] addr;
  logic          we_p, we_v, we_f;
  logic [63:0]   wd_p, wd_v, wd_f, rd_p, rd_v, rd_f;

  cvi_ram #(.Width(64), .Depth(MassCount)) u_pos (
    .clk_i, .we_i(we_p), .addr_i(addr), .wdata_i(wd_p), .rdata_o(rd_p));
  cvi_ram #(.Width(64), .Depth(MassCount)) u_vel (
    .clk_i, .we_i(we_v), .addr_i(addr), .wdata_i(wd_v), .rdata_o(rd_v));
  cvi_ram #(.Width(64), .Depth(MassCount)) u_frc (
    .clk_i, .we_i(we_f), .addr_i(addr), .wdata_i(wd_f), .rdata_o(rd_f));

  // Divider shared for both rescaled components.
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_quo;
  cvi_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num),
    .den_i({rt_res_q[32:0], 1'b0}), .done_o(dv_done), .quo_o(dv_quo));

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);

  logic [31:0] ax, ay;
  assign ax = vx_q[31] ? 32'(-vx_q) : 32'(vx_q);
  assign ay = vy_q[31] ? 32'(-vy_q) : 32'(vy_q);

  // Multiplier operand select by step.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_FX:  begin ma = 33'(fx_q); mb = 33'(dt_q); end
      S_FY:  begin ma = 33'(fy_q); mb = 33'(dt_q); end
      S_CAP: begin ma = 33'(cap_cfg_q); mb = 33'(dt_q); end
      S_SQX: begin ma = $signed({1'b0, ax}); mb = {1'b0, ax}; end
      S_SQY: begin ma = $signed({1'b0, ay}); mb = {1'b0, ay}; end
      S_CMP: begin ma = $signed(capv_q[32:0]); mb = capv_q[32:0]; end
      S_SQRT: begin ma = $signed({1'b0, ax}); mb = capv_q[32:0]; end
      S_WDX: begin ma = $signed({1'b0, ay}); mb = capv_q[32:0]; end
      S_MVX: begin ma = 33'(vx_q); mb = 33'(dt_q); end
      S_MVY: begin ma = 33'(vy_q); mb = 33'(dt_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Sequencer.
  logic [64:0] rt_trial;
  assign rt_trial = {1'b0, rt_res_q} + {1'b0, rt_bit_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == AW'(MassCount - 1)) state_d = S_IDLE;
      S_IDLE: if (in_acc) begin
        if ({1'b0, mass_index_i} >= (IndexWidth+1)'(MassCount)) state_d = S_IDLE;
        else if (req_type_i == ReqLoad) state_d = S_LOAD;
        else state_d = S_RD;
      end
      S_LOAD: state_d = S_IDLE;
      S_RD:   state_d = S_ACC;
      S_ACC:  state_d = last_q ? S_FX : S_IDLE;
      S_FX:   state_d = S_FY;
      S_FY:   state_d = S_CAP;
      S_CAP:  state_d = S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_CMP;
      S_CMP:  state_d = S_SQRT;
      S_SQRT: begin
        if (capbig_q || (sq_q <= 64'(mp_q))) state_d = S_MVX;
        else if (rt_cnt_q == 6'd32) state_d = S_DVX;
      end
      S_DVX:  state_d = S_WDX;
      S_WDX:  if (dv_done) state_d = S_DVY;
      S_DVY:  state_d = S_WDY;
      S_WDY:  if (dv_done) state_d = S_MVX;
      S_MVX:  state_d = S_MVY;
      S_MVY:  state_d = S_PX;
      S_PX:   state_d = S_PY;
      S_PY:   state_d = S_WR;
      S_WR:   state_d = S_OUT;
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    addr = (state_q == S_CLR) ? clr_q : AW'(idx_q);
    we_p = 1'b0; we_v = 1'b0; we_f = 1'b0;
    wd_p = {py_q, px_q};
    wd_v = {vy_q, vx_q};
    wd_f = '0;
    case (state_q)
      S_CLR:  we_f = 1'b1;
      S_LOAD: begin
        we_p = 1'b1; we_v = 1'b1; we_f = 1'b1;
        wd_p = {iy_q, ix_q};
        wd_v = '0;
      end
      S_ACC: begin
        we_f = 1'b1;
        wd_f = last_q ? 64'd0 :
          {sat32(34'(signed'(rd_f[63:32])) + 34'(iy_q)),
           sat32(34'(signed'(rd_f[31:0])) + 34'(ix_q))};
      end
      S_WR: begin we_p = 1'b1; we_v = 1'b1; end
      default: ;
    endcase
  end

  assign dv_start = (state_q == S_DVX) || (state_q == S_DVY);
  assign dv_num   = {vprod_q[62:0], 1'b0} + {30'd0, rt_res_q[32:0], 1'b0} - 64'd0
                    - {31'd0, rt_res_q[32:0]};

  // Rescaled component: sign, saturate.
  function automatic logic signed [31:0] fix(input logic [63:0] q, input logic neg);
    logic [31:0] m;
    logic signed [33:0] s;
    m = (q > 64'h80000000) ? 32'h80000000 : q[31:0];
    s = neg ? -$signed({2'b0, m}) : $signed({2'b0, m});
    if (q > 64'h80000000) begin
      return neg ? 32'sh80000000 : 32'sh7fffffff;
    end
    return sat32(s);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      dt_q      <= DtReset;
      cap_cfg_q <= CapReset;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + AW'(1);
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgIdxDt) dt_q <= cfg_data_i[DtWidth-1:0];
        else cap_cfg_q <= cfg_data_i[CapWidth-1:0];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mp_q <= mprod;
    if (in_acc) begin
      typ_q  <= req_type_i;
      idx_q  <= mass_index_i;
      ix_q   <= value_x_i;
      iy_q   <= value_y_i;
      last_q <= last_force_i;
    end
    case (state_q)
      S_ACC: begin
        fx_q <= sat32(34'(signed'(rd_f[31:0])) + 34'(ix_q));
        fy_q <= sat32(34'(signed'(rd_f[63:32])) + 34'(iy_q));
        vx_q <= rd_v[31:0];  vy_q <= rd_v[63:32];
        px_q <= rd_p[31:0];  py_q <= rd_p[63:32];
        capped_q <= 1'b0;
      end
      S_FY:  vx_q <= sat51(51'(vx_q) + mr);
      S_CAP: vy_q <= sat51(51'(vy_q) + mr);
      S_SQX: begin
        capv_q   <= 34'(mr);
        capbig_q <= mr[50:32] != '0;
      end
      S_SQY: sq_q <= 64'(mp_q);
      S_CMP: begin
        sq_q     <= sq_q + 64'(mp_q);
        rt_s_q   <= sq_q + 64'(mp_q);
        rt_res_q <= '0;
        rt_bit_q <= 64'h4000000000000000;
        rt_cnt_q <= '0;
      end
      S_SQRT: begin
        // One root digit a cycle; mp_q holds cap^2 from the previous step.
        if (rt_cnt_q == 6'd0) vprod_q <= 64'(mp_q);
        if (rt_cnt_q != 6'd32) begin
          rt_cnt_q <= rt_cnt_q + 6'd1;
          rt_bit_q <= rt_bit_q >> 2;
          if ({1'b0, rt_s_q} >= rt_trial) begin
            rt_s_q   <= rt_s_q - rt_trial[63:0];
            rt_res_q <= (rt_res_q >> 1) + rt_bit_q;
          end else begin
            rt_res_q <= rt_res_q >> 1;
          end
        end else begin
          vprod_q <= 64'(mp_q);
        end
      end
      S_WDX: begin
        if (dv_done) begin
          vprod_q  <= 64'(mp_q);
          vx_q     <= fix(dv_quo, vx_q[31]);
          capped_q <= 1'b1;
        end
      end
      S_WDY: if (dv_done) vy_q <= fix(dv_quo, vy_q[31]);
      // Each product lands in the step after its operands were selected.
      S_MVY: px_q <= sat51(51'(px_q) + mr);
      S_PX:  py_q <= sat51(51'(py_q) + mr);
      default: ;
    endcase
  end

  assign out_index_o  = idx_q;
  assign new_pos_x_o  = px_q;
  assign new_pos_y_o  = py_q;
  assign new_vel_x_o  = vx_q;
  assign new_vel_y_o  = vy_q;
  assign was_capped_o = capped_q;

  `ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, state_q != S_IDLE, in_stall_o, "taken while busy")
  `ASSERT_IMPL(a_out_only_force, clk_i, rst_ni, out_valid_o, typ_q == ReqForce && last_q,
    "result without last force")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable({out_index_o, new_pos_x_o, new_pos_y_o, new_vel_x_o, new_vel_y_o,
    was_capped_o}), "result changed while stalled")
endmodule
